>>> rtl/tbn_pkg.sv
// ============================================================================
// tbn_pkg: shared types, codes and role arithmetic for the barrier node
// Holds field widths, role/phase/action codes, the controller command and
// status words, and the functions that derive a node's role in a round.
// ============================================================================
package tbn_pkg;

  localparam int MAX_NODES = 64;

  localparam int RANK_W  = 6;
  localparam int COUNT_W = 7;
  localparam int ROUND_W = 3;
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 2;
  localparam int OPP_W   = 8;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_NODE_RANK  = 2'd0;
  localparam logic [IDX_W-1:0] REG_NODE_COUNT = 2'd1;

  // Role of this node in one round.
  localparam logic [1:0] ROLE_NONE     = 2'd0;
  localparam logic [1:0] ROLE_WINNER   = 2'd1;
  localparam logic [1:0] ROLE_LOSER    = 2'd2;
  localparam logic [1:0] ROLE_CHAMPION = 2'd3;

  // Barrier phase.
  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_WAIT_TOKEN = 2'd1;
  localparam logic [1:0] PH_WAIT_WAKE  = 2'd2;

  // Result actions.
  localparam logic [ACT_W-1:0] ACT_SEND    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLAG    = 2'd2;

  // Round counter operations.
  localparam logic [2:0] K_KEEP    = 3'd0;
  localparam logic [2:0] K_ONE     = 3'd1;
  localparam logic [2:0] K_CUR_DEC = 3'd2;
  localparam logic [2:0] K_CUR_INC = 3'd3;
  localparam logic [2:0] K_INC     = 3'd4;
  localparam logic [2:0] K_DEC     = 3'd5;

  // Phase register operations.
  localparam logic [1:0] PHOP_KEEP  = 2'd0;
  localparam logic [1:0] PHOP_TOKEN = 2'd1;
  localparam logic [1:0] PHOP_WAKE  = 2'd2;
  localparam logic [1:0] PHOP_CLEAR = 2'd3;

  typedef struct packed {
    logic             in_ready;
    logic             sel_cur;
    logic [2:0]       k_op;
    logic [1:0]       ph_op;
    logic             emit;
    logic [ACT_W-1:0] emit_act;
    logic             emit_last;
  } tbn_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic       req_type;
    logic [1:0] phase;
    logic       rank_bad;
    logic       token_ok;
    logic [1:0] role;
    logic       k_past;
    logic       k_zero;
    logic       out_free;
  } tbn_status_t;

  typedef struct packed {
    logic [1:0]       role;
    logic [OPP_W-1:0] opp;
  } role_info_t;

  // Node count clamped to [2, MAX_NODES].
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = c;
    if (c < COUNT_W'(2)) r = COUNT_W'(2);
    else if (c > COUNT_W'(MAX_NODES)) r = COUNT_W'(MAX_NODES);
    return r;
  endfunction

  // Smallest number of rounds whose span covers the node count.
  function automatic logic [ROUND_W-1:0] round_total(input logic [COUNT_W-1:0] p);
    logic [ROUND_W-1:0] t;
    logic               found;
    t     = '0;
    found = 1'b0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (!found && ((OPP_W'(1) << i) >= OPP_W'(p))) begin
        t     = ROUND_W'(i);
        found = 1'b1;
      end
    end
    return t;
  endfunction

  // Role and opponent of a node in round k.
  function automatic role_info_t role_of(input logic [RANK_W-1:0]  rank,
                                         input logic [COUNT_W-1:0] p,
                                         input logic [ROUND_W-1:0] k);
    logic [OPP_W-1:0] r8;
    logic [OPP_W-1:0] p8;
    logic [OPP_W-1:0] full;
    logic [OPP_W-1:0] half;
    logic [OPP_W-1:0] mask;
    role_info_t       ri;
    r8      = OPP_W'(rank);
    p8      = OPP_W'(p);
    full    = OPP_W'(1) << k;
    half    = full >> 1;
    mask    = full - OPP_W'(1);
    ri.role = ROLE_NONE;
    ri.opp  = '0;
    if (k != '0) begin
      if (r8 == '0 && full >= p8) begin
        ri.role = ROLE_CHAMPION;
        ri.opp  = r8 + half;
      end else if ((r8 & mask) == '0) begin
        if ((r8 + half) < p8 && full < p8) begin
          ri.role = ROLE_WINNER;
          ri.opp  = r8 + half;
        end
      end else if ((r8 & mask) == half) begin
        ri.role = ROLE_LOSER;
        ri.opp  = r8 - half;
      end
    end
    return ri;
  endfunction

endpackage

>>> rtl/tbn_item_if.sv
// ============================================================================
// tbn_item_if: input channel of the barrier node
// Carries one request word: a local arrival or a received token.
// ============================================================================
interface tbn_item_if import tbn_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [RANK_W-1:0]  msg_source;
  logic [ROUND_W-1:0] msg_round;

  modport source(output valid, req_type, msg_source, msg_round, input ready);
  modport sink(input valid, req_type, msg_source, msg_round, output ready);
endinterface

>>> rtl/tbn_result_if.sv
// ============================================================================
// tbn_result_if: result channel of the barrier node
// Carries one result word: a token to send, a release or a flagged request.
// ============================================================================
interface tbn_result_if import tbn_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [RANK_W-1:0]  dest_rank;
  logic [ROUND_W-1:0] tag_round;
  logic               last;

  modport source(output valid, action, dest_rank, tag_round, last, input ready);
  modport sink(input valid, action, dest_rank, tag_round, last, output ready);
endinterface

>>> rtl/tbn_cfg_if.sv
// ============================================================================
// tbn_cfg_if: configuration write channel of the barrier node
// Carries a register index and the data word to write there.
// ============================================================================
interface tbn_cfg_if import tbn_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   index;
  logic [COUNT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/tbn_datapath.sv
// ============================================================================
// tbn_datapath: registers and role logic of the barrier node
// Holds configuration, barrier phase, round counter, the latched request
// and the output register; evaluates the role of the selected round.
// ============================================================================
module tbn_datapath import tbn_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  tbn_cfg_if.sink       cfg,
  tbn_item_if.sink      item,
  tbn_result_if.source  result,
  input  tbn_cmd_t      cmd,
  output tbn_status_t   status
);

  logic [RANK_W-1:0]  node_rank;
  logic [COUNT_W-1:0] node_count;
  logic [1:0]         phase;
  logic [ROUND_W-1:0] current_round;
  logic [ROUND_W-1:0] k;
  logic [ROUND_W-1:0] k_next;

  logic               in_req;
  logic [RANK_W-1:0]  in_source;
  logic [ROUND_W-1:0] in_round;

  logic               out_valid;
  logic [ACT_W-1:0]   out_action;
  logic [RANK_W-1:0]  out_dest;
  logic [ROUND_W-1:0] out_tag;
  logic               out_last;

  logic [COUNT_W-1:0] p;
  logic [ROUND_W-1:0] total;
  logic [ROUND_W-1:0] rsel;
  role_info_t         ri;
  logic               out_free;

  assign p        = eff_count(node_count);
  assign total    = round_total(p);
  assign rsel     = cmd.sel_cur ? current_round : k;
  assign ri       = role_of(node_rank, p, rsel);
  assign out_free = !out_valid || result.ready;

  assign cfg.ready  = 1'b1;
  assign item.ready = cmd.in_ready;

  assign result.valid     = out_valid;
  assign result.action    = out_action;
  assign result.dest_rank = out_dest;
  assign result.tag_round = out_tag;
  assign result.last      = out_last;

  always_comb begin
    status.in_valid = item.valid;
    status.req_type = in_req;
    status.phase    = phase;
    status.rank_bad = OPP_W'(node_rank) >= OPP_W'(p);
    status.token_ok = (in_source == ri.opp[RANK_W-1:0]) && (in_round == current_round);
    status.role     = ri.role;
    status.k_past   = k > total;
    status.k_zero   = k == '0;
    status.out_free = out_free;
  end

  always_comb begin
    case (cmd.k_op)
      K_ONE:     k_next = ROUND_W'(1);
      K_CUR_DEC: k_next = current_round - ROUND_W'(1);
      K_CUR_INC: k_next = current_round + ROUND_W'(1);
      K_INC:     k_next = k + ROUND_W'(1);
      K_DEC:     k_next = k - ROUND_W'(1);
      default:   k_next = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_rank     <= '0;
      node_count    <= COUNT_W'(2);
      phase         <= PH_IDLE;
      current_round <= '0;
      k             <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_NODE_RANK:  node_rank  <= cfg.data[RANK_W-1:0];
          REG_NODE_COUNT: node_count <= cfg.data;
          default: ;
        endcase
      end
      k <= k_next;
      case (cmd.ph_op)
        PHOP_TOKEN: begin
          phase         <= PH_WAIT_TOKEN;
          current_round <= k;
        end
        PHOP_WAKE: begin
          phase         <= PH_WAIT_WAKE;
          current_round <= k;
        end
        PHOP_CLEAR: begin
          phase         <= PH_IDLE;
          current_round <= '0;
        end
        default: ;
      endcase
      if (cmd.emit) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Request latch and output payload carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.in_ready && item.valid) begin
      in_req    <= item.req_type;
      in_source <= item.msg_source;
      in_round  <= item.msg_round;
    end
    if (cmd.emit) begin
      out_action <= cmd.emit_act;
      out_last   <= cmd.emit_last;
      if (cmd.emit_act == ACT_SEND) begin
        out_dest <= ri.opp[RANK_W-1:0];
        out_tag  <= rsel;
      end else begin
        out_dest <= '0;
        out_tag  <= '0;
      end
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result word loaded while the output register is still occupied");

  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_act == ACT_RELEASE) |=> (phase == PH_IDLE && current_round == '0))
    else $error("release did not return the node to idle");

  a_wait_round: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (current_round != '0))
    else $error("node waits in round zero");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.in_ready |-> (!cmd.emit && cmd.ph_op == PHOP_KEEP))
    else $error("state changed while waiting for a request");

endmodule

>>> rtl/tbn_controller.sv
// ============================================================================
// tbn_controller: sequencer of the barrier node
// Decides how a request is handled, then steps up through the rounds to
// climb, or down through the rounds to wake the beaten losers.
// ============================================================================
module tbn_controller import tbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tbn_status_t status,
  output tbn_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_CLIMB  = 2'd2;
  localparam logic [1:0] S_WAKE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.sel_cur = 1'b1;
        if ((!status.req_type && (status.phase != PH_IDLE || status.rank_bad)) ||
            (status.req_type && (status.phase == PH_IDLE || !status.token_ok))) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_act  = ACT_FLAG;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (!status.req_type) begin
          cmd.k_op   = K_ONE;
          state_next = S_CLIMB;
        end else if (status.phase == PH_WAIT_WAKE) begin
          cmd.k_op   = K_CUR_DEC;
          state_next = S_WAKE;
        end else if (status.role == ROLE_CHAMPION) begin
          // The champion wakes its last opponent before the lower rounds.
          if (status.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_act = ACT_SEND;
            cmd.k_op     = K_CUR_DEC;
            state_next   = S_WAKE;
          end
        end else if (status.role == ROLE_WINNER) begin
          cmd.k_op   = K_CUR_INC;
          state_next = S_CLIMB;
        end else begin
          // Role lost through reconfiguration: finish the barrier.
          cmd.k_op   = K_CUR_DEC;
          state_next = S_WAKE;
        end
      end
      S_CLIMB: begin
        if (status.k_past) begin
          cmd.k_op   = K_DEC;
          state_next = S_WAKE;
        end else if (status.role == ROLE_WINNER || status.role == ROLE_CHAMPION) begin
          cmd.ph_op  = PHOP_TOKEN;
          state_next = S_IDLE;
        end else if (status.role == ROLE_LOSER) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_act  = ACT_SEND;
            cmd.emit_last = 1'b1;
            cmd.ph_op     = PHOP_WAKE;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.k_op = K_INC;
        end
      end
      S_WAKE: begin
        if (status.k_zero) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_act  = ACT_RELEASE;
            cmd.emit_last = 1'b1;
            cmd.ph_op     = PHOP_CLEAR;
            state_next    = S_IDLE;
          end
        end else if (status.role == ROLE_WINNER) begin
          if (status.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_act = ACT_SEND;
            cmd.k_op     = K_DEC;
          end
        end else begin
          cmd.k_op = K_DEC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

>>> rtl/tournament_barrier_node.sv
// ============================================================================
// tournament_barrier_node: one node's controller in a tournament barrier
// Tracks this node's rounds and emits the tokens and release it owes, or flags a bad request.
// ============================================================================
// Channels: item takes a local arrival (req_type 0) or a received token
// (req_type 1, with its source rank and round tag). result gives words of
// action, dest_rank, tag_round and last; last marks the final word of a
// request, and a request that only parks the node to wait gives no word.
// cfg writes node_rank (index 0) and node_count (index 1); the user must
// write them only while idle, which the block itself does not enforce.
// A request is latched while idle and decided in the decide state; each
// round the node climbs through, or walks down to wake a beaten loser, is
// one step of the round counter. A new request is taken as soon as the
// sequencer returns to idle, even if the final word still sits in the
// output register. Each emitted word waits for that register to free.
// Reset clears the registers to rank 0, count 2, idle, round 0, and
// empties the output register. When the receiver stalls, the sequencer
// holds its place until the pending word is taken; no word is lost.
module tournament_barrier_node import tbn_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tbn_cfg_if.sink      cfg,
  tbn_item_if.sink     item,
  tbn_result_if.source result
);

  tbn_cmd_t    cmd;
  tbn_status_t status;

  tbn_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  tbn_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .status (status)
  );

endmodule

>>> tb/tbn_node_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// tbn_node_checker: result predictor and scoreboard for the barrier node
// Watches the configuration, request and result channels. It keeps its own
// copy of the node registers and barrier state, works out the words that
// each accepted request must produce, and compares every accepted result
// word field by field against the oldest pending prediction.
// ============================================================================
module tbn_node_checker import tbn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  tbn_cfg_if                 cfg,
  tbn_item_if                item,
  tbn_result_if              result,
  output int                 mismatches,
  output int                 words_due,
  output logic               in_barrier,
  output logic [RANK_W-1:0]  want_src,
  output logic [ROUND_W-1:0] want_round
);

  localparam int BURST_CAP = 8;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [RANK_W-1:0]  dest_rank;
    logic [ROUND_W-1:0] tag_round;
    logic               last;
  } node_word_t;

  node_word_t         due_q[$];
  node_word_t         burst[BURST_CAP];
  int                 burst_len;
  int                 fail_tally = 0;
  logic [RANK_W-1:0]  rank_reg;
  logic [COUNT_W-1:0] count_reg;
  logic [1:0]         barrier_ph;
  int                 wait_round;

  assign mismatches = fail_tally;

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    fail_tally++;
  endtask

  function automatic int live_count();
    int c;
    c = count_reg;
    if (c < 2) c = 2;
    if (c > MAX_NODES) c = MAX_NODES;
    return c;
  endfunction

  function automatic int rounds_for_count();
    int p;
    int r;
    p = live_count();
    r = 0;
    while ((1 << r) < p) r++;
    return r;
  endfunction

  // Role of this node in round k under the current registers.
  function automatic logic [1:0] round_role(input int k, output int opp);
    int p;
    int r;
    int full;
    int half;
    p   = live_count();
    r   = rank_reg;
    opp = 0;
    if (k <= 0) return ROLE_NONE;
    full = 1 << k;
    half = full >> 1;
    if (r == 0 && full >= p) begin
      opp = half;
      return ROLE_CHAMPION;
    end
    if (r % full == 0) begin
      if (r + half < p && full < p) begin
        opp = r + half;
        return ROLE_WINNER;
      end
      return ROLE_NONE;
    end
    if (r % full == half) begin
      opp = r - half;
      return ROLE_LOSER;
    end
    return ROLE_NONE;
  endfunction

  // A full burst drops further sends; a release always takes the final slot.
  task automatic emit(input logic [ACT_W-1:0] act, input int dst, input int tag);
    node_word_t w;
    if (burst_len >= BURST_CAP) begin
      if (act == ACT_SEND) return;
      burst_len = BURST_CAP - 1;
    end
    w.action    = act;
    w.dest_rank = RANK_W'(dst);
    w.tag_round = ROUND_W'(tag);
    w.last      = 1'b0;
    burst[burst_len] = w;
    burst_len++;
  endtask

  // Wake every loser beaten below round 'from', highest first, then release.
  task automatic wake_losers(input int from);
    int k;
    int opp;
    for (k = from; k > 1; k--) begin
      if (round_role(k - 1, opp) == ROLE_WINNER) emit(ACT_SEND, opp, k - 1);
    end
    emit(ACT_RELEASE, 0, 0);
    barrier_ph = PH_IDLE;
    wait_round = 0;
  endtask

  task automatic climb_from(input int k0);
    int         k;
    int         total;
    int         opp;
    logic [1:0] role;
    total = rounds_for_count();
    for (k = k0; k <= total; k++) begin
      role = round_role(k, opp);
      if (role == ROLE_WINNER || role == ROLE_CHAMPION) begin
        barrier_ph = PH_WAIT_TOKEN;
        wait_round = k & 7;
        return;
      end
      if (role == ROLE_LOSER) begin
        emit(ACT_SEND, opp, k);
        barrier_ph = PH_WAIT_WAKE;
        wait_round = k & 7;
        return;
      end
    end
    wake_losers(k);
  endtask

  task automatic predict_request(input logic is_token, input logic [RANK_W-1:0] src,
                                 input logic [ROUND_W-1:0] rnd);
    int         opp;
    logic [1:0] role;
    burst_len = 0;
    if (!is_token) begin
      if (barrier_ph != PH_IDLE || int'(rank_reg) >= live_count()) emit(ACT_FLAG, 0, 0);
      else climb_from(1);
    end else if (barrier_ph == PH_IDLE) begin
      emit(ACT_FLAG, 0, 0);
    end else begin
      role = round_role(wait_round, opp);
      if (int'(src) != (opp & 63) || int'(rnd) != wait_round) begin
        emit(ACT_FLAG, 0, 0);
      end else if (barrier_ph == PH_WAIT_WAKE) begin
        wake_losers(wait_round);
      end else if (role == ROLE_CHAMPION) begin
        emit(ACT_SEND, opp, wait_round);
        wake_losers(wait_round);
      end else if (role == ROLE_WINNER) begin
        climb_from(wait_round + 1);
      end else begin
        // The registers changed under a waiting node: it just finishes.
        wake_losers(wait_round);
      end
    end
    if (burst_len > 0) burst[burst_len - 1].last = 1'b1;
    for (int i = 0; i < burst_len; i++) due_q.push_back(burst[i]);
  endtask

  task automatic check_word(input node_word_t got);
    node_word_t want;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word: action %0d dest %0d round %0d last %0d",
                                got.action, got.dest_rank, got.tag_round, got.last));
      return;
    end
    want = due_q.pop_front();
    if (got.action != want.action)
      report_mismatch($sformatf("action: got %0d, expected %0d", got.action, want.action));
    if (got.dest_rank != want.dest_rank)
      report_mismatch($sformatf("dest_rank: got %0d, expected %0d",
                                got.dest_rank, want.dest_rank));
    if (got.tag_round != want.tag_round)
      report_mismatch($sformatf("tag_round: got %0d, expected %0d",
                                got.tag_round, want.tag_round));
    if (got.last != want.last)
      report_mismatch($sformatf("last: got %0d, expected %0d", got.last, want.last));
  endtask

  always @(posedge clk) begin
    node_word_t seen_w;
    int         opp;
    if (rst) begin
      rank_reg   = '0;
      count_reg  = COUNT_W'(2);
      barrier_ph = PH_IDLE;
      wait_round = 0;
      due_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_NODE_RANK:  rank_reg = cfg.data[RANK_W-1:0];
          REG_NODE_COUNT: count_reg = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        predict_request(item.req_type, item.msg_source, item.msg_round);
      if (result.valid && result.ready) begin
        seen_w.action    = result.action;
        seen_w.dest_rank = result.dest_rank;
        seen_w.tag_round = result.tag_round;
        seen_w.last      = result.last;
        check_word(seen_w);
      end
    end
    // Published through registers so the stimulus side never races the update.
    void'(round_role(wait_round, opp));
    words_due  <= due_q.size();
    in_barrier <= (barrier_ph != PH_IDLE);
    want_src   <= RANK_W'(opp);
    want_round <= ROUND_W'(wait_round);
  end

endmodule

>>> tb/tb_tournament_barrier_node.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_tournament_barrier_node: testbench for one tournament barrier node
// Drives arrivals and tokens with random gaps and result back-pressure,
// mostly as complete barriers that follow the awaited token, mixed with
// stray tokens, repeated arrivals and register changes, over many settings.
// ============================================================================
module tb_tournament_barrier_node import tbn_pkg::*; ;

  localparam logic REQ_ARRIVE  = 1'b0;
  localparam logic REQ_TOKEN   = 1'b1;
  localparam int   IDLE_PCT    = 23;
  localparam int   RANDOM_REQS = 230;
  localparam int   SETTLE      = 24;
  localparam int   CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  logic no_idle;
  int   items_done = 0;
  int   random_base;
  int   cycle_count = 0;

  int                 chk_errors;
  int                 chk_words_due;
  logic               chk_in_barrier;
  logic [RANK_W-1:0]  chk_want_src;
  logic [ROUND_W-1:0] chk_want_round;

  tbn_cfg_if    cfg_ch();
  tbn_item_if   item_ch();
  tbn_result_if res_ch();

  tournament_barrier_node dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  tbn_node_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .item       (item_ch),
    .result     (res_ch),
    .mismatches (chk_errors),
    .words_due  (chk_words_due),
    .in_barrier (chk_in_barrier),
    .want_src   (chk_want_src),
    .want_round (chk_want_round)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    res_ch.ready <= !rst && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_tournament_barrier_node: FAIL");
      $finish;
    end
  end

  // Returns at the edge where the word was taken; valid is left high.
  task automatic send_item(input logic req, input logic [RANK_W-1:0] src,
                           input logic [ROUND_W-1:0] rnd);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.req_type   <= req;
    item_ch.msg_source <= src;
    item_ch.msg_round  <= rnd;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_done++;
  endtask

  // Register writes wait until the node has nothing left to say.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COUNT_W-1:0] value);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_words_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_node(input int rank, input int count);
    write_reg(REG_NODE_COUNT, COUNT_W'(count));
    write_reg(REG_NODE_RANK, {1'($urandom), RANK_W'(rank)});
  endtask

  task automatic pick_setting();
    int sel;
    int cnt;
    sel = $urandom_range(0, 9);
    case (sel)
      0: set_node(0, 64);
      1: set_node(63, 64);
      2: set_node(0, 2);
      3: set_node(1, 2);
      4: set_node($urandom_range(0, 1), 0);
      5: set_node($urandom_range(0, 63), 127);
      6: set_node($urandom_range(0, 1), 1);
      7: set_node($urandom_range(0, 63), $urandom_range(2, 64));
      default: begin
        cnt = $urandom_range(2, 64);
        set_node($urandom_range(0, cnt - 1), cnt);
      end
    endcase
  endtask

  // One barrier from arrival to release, with noise mixed in at noise_pct.
  task automatic drive_barrier(input int noise_pct);
    int sel;
    send_item(REQ_ARRIVE, RANK_W'($urandom), ROUND_W'($urandom));
    for (int step = 0; step < 24; step++) begin
      // Drop valid before the checker is read, so the awaited token reflects the last request.
      item_ch.valid <= 1'b0;
      @(posedge clk);
      if (!chk_in_barrier) break;
      if ($urandom_range(0, 99) < noise_pct) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) send_item(REQ_TOKEN, RANK_W'($urandom), ROUND_W'($urandom));
        else if (sel < 8) send_item(REQ_ARRIVE, RANK_W'($urandom), ROUND_W'($urandom));
        else pick_setting();
      end else begin
        send_item(REQ_TOKEN, chk_want_src, chk_want_round);
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    no_idle            <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_NODE_RANK;
    cfg_ch.data        <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.req_type   <= REQ_ARRIVE;
    item_ch.msg_source <= '0;
    item_ch.msg_round  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: rank 0 of two nodes, so the node is champion in round 1.
    send_item(REQ_TOKEN, 6'd63, 3'd7);
    send_item(REQ_ARRIVE, 6'd0, 3'd0);
    send_item(REQ_ARRIVE, 6'd63, 3'd7);
    send_item(REQ_TOKEN, 6'd0, 3'd1);
    send_item(REQ_TOKEN, 6'd1, 3'd2);
    send_item(REQ_TOKEN, 6'd1, 3'd1);

    set_node(1, 2);
    send_item(REQ_ARRIVE, 6'd0, 3'd0);
    send_item(REQ_TOKEN, 6'd0, 3'd1);

    // Full tree: a six-round champion, the last loser, and a deep winner.
    set_node(0, 64);
    drive_barrier(0);
    set_node(63, 64);
    drive_barrier(0);
    set_node(32, 127);
    drive_barrier(0);
    set_node(63, 2);
    send_item(REQ_ARRIVE, 6'd0, 3'd0);
    set_node(1, 0);
    drive_barrier(0);

    random_base = items_done;
    while (items_done - random_base < RANDOM_REQS) begin
      no_idle <= (items_done - random_base >= 110) && (items_done - random_base < 170);
      case ($urandom_range(0, 99)) inside
        [0:7]:   pick_setting();
        [8:19]:  send_item(1'($urandom), RANK_W'($urandom), ROUND_W'($urandom));
        default: drive_barrier(15);
      endcase
    end

    item_ch.valid <= 1'b0;
    no_idle       <= 1'b0;
    @(posedge clk);
    while (chk_words_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (chk_errors == 0) begin
      $display("tb_tournament_barrier_node: PASS");
    end else begin
      $display("tb_tournament_barrier_node: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tbn_pkg.sv
rtl/tbn_item_if.sv
rtl/tbn_result_if.sv
rtl/tbn_cfg_if.sv
rtl/tbn_datapath.sv
rtl/tbn_controller.sv
rtl/tournament_barrier_node.sv
tb/tbn_node_checker.sv
tb/tb_tournament_barrier_node.sv
